// ===== src/fha_pkg.sv =====
// Shared types, codes and constants for the first-fit heap allocator.
// No dependencies; imported by every module of the block.
package fha_pkg;

  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int HEADER_BYTES_DEF = 8;
  localparam int LIMIT_W          = 17;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd2048;
  localparam int CW               = 19;  // width for need and split compares
  localparam int SPLIT_SLACK      = 16;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  typedef struct packed {
    logic        action;
    logic [15:0] request_size;
    logic [15:0] block_address;
  } in_t;

  typedef struct packed {
    logic [15:0] payload_address;
    logic [1:0]  status;
  } out_t;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_A_SEED,
    CMD_A_FIRST,
    CMD_A_STEP,
    CMD_A_SPLIT1,
    CMD_A_SPLIT2,
    CMD_A_TAKE,
    CMD_F_RDH,
    CMD_F_CLR,
    CMD_F_STEP,
    CMD_F_LAST,
    CMD_F_RD1,
    CMD_F_RD2,
    CMD_F_CALC,
    CMD_F_M1,
    CMD_F_M2,
    CMD_RES
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] code;
  } ctl_t;

  typedef struct packed {
    logic act;
    logic refuse;
    logic empty;
    logic bad;
    logic used;
    logic found;
    logic split;
    logic a_end;
    logic f_brk;
    logic f_end;
  } sts_t;

endpackage

// ===== src/first_fit_heap_allocator.sv =====
// First-fit heap allocator: top level joining fha_ctrl and fha_datapath.
// Depends on fha_pkg, fha_ctrl, fha_datapath.
//
// Requests arrive on in_valid/in_ready (in_data: action, request_size,
// block_address); one result per request leaves on out_valid/out_ready
// (out_data: payload_address, status). cfg_valid/cfg_ready writes the
// large request limit and is always ready; write it only while idle.
// One request is worked at a time. An allocate that is refused or finds an
// empty list ends without a search. A search examines the free blocks, one
// per cycle of the size and link memory read ports, and ends when nothing
// fits, when the block found is taken whole or when it is split.
// A free ends without a walk for a malformed address, when the block is not
// in use or when the list was empty; else it walks the list to find the
// block's place in the address order, with a last step when that walk wraps
// around to the rover.
// Results sit in an output register: while the receiver stalls the next
// request is still accepted and worked, and waits only to hand over its
// result. Reset empties the result register and leaves the whole heap as
// one free block at offset zero; no clearing pass is run.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = fha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = fha_pkg::HEADER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fha_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fha_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fha_pkg::LIMIT_W-1:0] cfg_data
);
  import fha_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  fha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  fha_datapath #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== src/fha_datapath.sv =====
// Datapath: size and link memories, rover, walk registers and result register.
// Driven by commands from fha_ctrl; depends on fha_pkg.
module fha_datapath #(
  parameter int HEAP_BYTES   = fha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = fha_pkg::HEADER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fha_pkg::in_t                 in_data,
  input  logic                         cfg_we,
  input  logic [fha_pkg::LIMIT_W-1:0]  cfg_data,
  input  fha_pkg::ctl_t                ctl,
  output fha_pkg::sts_t                sts,
  output fha_pkg::out_t                out_data
);
  import fha_pkg::*;

  localparam int SLOTS = HEAP_BYTES / 8;
  localparam int SW    = $clog2(SLOTS);
  localparam int SZW   = $clog2(HEAP_BYTES) + 2;
  localparam int NW    = (SZW > CW) ? SZW : CW;
  localparam int HDR   = ((HEADER_BYTES + 7) / 8) * 8;
  localparam logic [SZW-1:0] SIZE0_RESET = SZW'(HEAP_BYTES - HDR);
  localparam logic [SW-1:0]  K_LAST      = SW'(SLOTS - 1);

  logic [SZW-1:0] size_mem [SLOTS];
  logic [SW-1:0]  link_mem [SLOTS];

  logic [LIMIT_W-1:0] limit_r;
  logic               act_r, refuse_r, bad_r, empty_r;
  logic [NW-1:0]      need_r, needsp_r;
  logic [SW-1:0]      h_r, prev_r, curr_r, rover_r, k_r, nl_r, rest_r;
  logic [SW-1:0]      lkc_r, linkh_r, prev2_r;
  logic [SZW-1:0]     cs_r, hs_r, szc_r, hs2_r, szp_r, sum_r;
  logic               back_r;
  logic [15:0]        pay_r;
  out_t               out_r;
  logic [SZW-1:0]     sz_q;
  logic [SW-1:0]      lk_q;
  logic               szz_q, lkz_q, sz0_ok_r, lk0_ok_r;

  logic               sz_we, lk_we;
  logic [SW-1:0]      sz_wa, lk_wa, sz_ra, lk_ra;
  logic [SZW-1:0]     sz_wd;
  logic [SW-1:0]      lk_wd;

  logic [SZW-1:0] sz_rd, sz_clean;
  logic [SW-1:0]  lk_rd;
  logic [16:0]    rnd, hb;
  logic [NW-1:0]  need_c;
  logic           fwd, same;
  logic [SW-1:0]  lk_eff, prev2_c, rest_c;
  logic [SZW-1:0] hs2_c;
  logic [31:0]    pay_w;

  assign sz_rd    = szz_q ? SIZE0_RESET : sz_q;
  assign sz_clean = {sz_rd[SZW-1:1], 1'b0};
  assign lk_rd    = lkz_q ? '0 : lk_q;

  assign rnd    = (17'(in_data.request_size) + 17'd7) & ~17'd7;
  assign need_c = NW'(rnd) + NW'(HDR);
  assign hb     = 17'(in_data.block_address) - 17'(HDR);

  assign same    = (prev_r == curr_r);
  assign fwd     = (32'({h_r, 3'b000}) + 32'(hs_r)) == 32'({curr_r, 3'b000});
  assign lk_eff  = same ? h_r : lkc_r;
  assign hs2_c   = fwd ? hs_r + szc_r : hs_r;
  assign prev2_c = (fwd && same) ? h_r : prev_r;
  assign rest_c  = SW'(32'(curr_r) + 32'(need_r[NW-1:3]));
  assign pay_w   = 32'({curr_r, 3'b000}) + 32'(HDR);

  always_comb begin
    sts.act    = act_r;
    sts.refuse = refuse_r;
    sts.empty  = empty_r;
    sts.bad    = bad_r;
    sts.used   = sz_rd[0];
    sts.found  = NW'(sz_clean) >= need_r;
    sts.split  = NW'(sz_clean) >= needsp_r;
    sts.a_end  = (curr_r == rover_r) || (k_r == K_LAST);
    sts.f_brk  = (h_r > prev_r && h_r < lk_rd) ||
                 (prev_r >= lk_rd && (h_r > prev_r || h_r < lk_rd));
    sts.f_end  = (lk_rd == rover_r) || (k_r == K_LAST);
  end

  always_comb begin
    sz_we = 1'b0;
    sz_wa = curr_r;
    sz_wd = '0;
    lk_we = 1'b0;
    lk_wa = prev_r;
    lk_wd = '0;
    sz_ra = curr_r;
    lk_ra = curr_r;
    case (ctl.cmd)
      CMD_A_SEED: lk_ra = rover_r;
      CMD_A_FIRST, CMD_A_STEP: begin
        sz_ra = lk_rd;
        lk_ra = lk_rd;
      end
      CMD_A_SPLIT1: begin
        sz_we = 1'b1;
        sz_wa = rest_c;
        sz_wd = cs_r - SZW'(need_r);
        lk_we = 1'b1;
        lk_wa = rest_c;
        lk_wd = same ? rest_c : nl_r;
      end
      CMD_A_SPLIT2: begin
        sz_we = 1'b1;
        sz_wa = curr_r;
        sz_wd = SZW'(need_r) | SZW'(1);
        lk_we = !same;
        lk_wa = prev_r;
        lk_wd = rest_r;
      end
      CMD_A_TAKE: begin
        sz_we = 1'b1;
        sz_wa = curr_r;
        sz_wd = cs_r | SZW'(1);
        lk_we = !same;
        lk_wa = prev_r;
        lk_wd = nl_r;
      end
      CMD_F_RDH: sz_ra = h_r;
      CMD_F_CLR: begin
        sz_we = 1'b1;
        sz_wa = h_r;
        sz_wd = sz_clean;
        lk_we = empty_r;
        lk_wa = h_r;
        lk_wd = h_r;
        lk_ra = rover_r;
      end
      CMD_F_STEP: lk_ra = lk_rd;
      CMD_F_RD2:  sz_ra = prev_r;
      CMD_F_M1: begin
        sz_we = 1'b1;
        sz_wa = h_r;
        sz_wd = hs2_r;
        lk_we = 1'b1;
        lk_wa = h_r;
        lk_wd = linkh_r;
      end
      CMD_F_M2: begin
        sz_we = back_r;
        sz_wa = prev2_r;
        sz_wd = sum_r;
        lk_we = 1'b1;
        lk_wa = prev_r;
        lk_wd = (back_r && prev2_r == prev_r) ? linkh_r : h_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sz_we) size_mem[sz_wa] <= sz_wd;
    if (lk_we) link_mem[lk_wa] <= lk_wd;
    sz_q  <= size_mem[sz_ra];
    lk_q  <= link_mem[lk_ra];
    szz_q <= (sz_ra == '0) && !(sz0_ok_r || (sz_we && sz_wa == '0));
    lkz_q <= (lk_ra == '0) && !(lk0_ok_r || (lk_we && lk_wa == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      rover_r  <= '0;
      empty_r  <= 1'b0;
      sz0_ok_r <= 1'b0;
      lk0_ok_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_data;
      if (sz_we && sz_wa == '0) sz0_ok_r <= 1'b1;
      if (lk_we && lk_wa == '0) lk0_ok_r <= 1'b1;
      case (ctl.cmd)
        CMD_A_SPLIT2: rover_r <= same ? rest_r : prev_r;
        CMD_A_TAKE: begin
          if (same) empty_r <= 1'b1;
          else rover_r <= prev_r;
        end
        CMD_F_CLR: begin
          if (empty_r) begin
            rover_r <= h_r;
            empty_r <= 1'b0;
          end
        end
        CMD_F_M2: rover_r <= prev2_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_LOAD: begin
        act_r    <= in_data.action;
        refuse_r <= (in_data.request_size == 16'd0) ||
                    (LIMIT_W'(in_data.request_size) >= limit_r);
        need_r   <= need_c;
        needsp_r <= need_c + NW'(HDR) + NW'(SPLIT_SLACK);
        bad_r    <= (17'(in_data.block_address) < 17'(HDR)) || (hb[2:0] != 3'd0) ||
                    (32'(hb[16:3]) >= 32'(SLOTS));
        h_r      <= SW'(hb[16:3]);
      end
      CMD_A_SEED: begin
        prev_r <= rover_r;
        k_r    <= '0;
      end
      CMD_A_FIRST: curr_r <= lk_rd;
      CMD_A_STEP: begin
        cs_r <= sz_clean;
        nl_r <= lk_rd;
        if (!sts.found) begin
          prev_r <= curr_r;
          curr_r <= lk_rd;
          k_r    <= k_r + SW'(1);
        end
      end
      CMD_A_SPLIT1: rest_r <= rest_c;
      CMD_A_SPLIT2, CMD_A_TAKE: pay_r <= pay_w[15:0];
      CMD_F_CLR: begin
        hs_r   <= sz_clean;
        prev_r <= rover_r;
        k_r    <= '0;
      end
      CMD_F_STEP: begin
        if (sts.f_brk) begin
          curr_r <= lk_rd;
        end else begin
          prev_r <= lk_rd;
          k_r    <= k_r + SW'(1);
        end
      end
      CMD_F_LAST: curr_r <= lk_rd;
      CMD_F_RD2: begin
        szc_r <= sz_clean;
        lkc_r <= lk_rd;
      end
      CMD_F_CALC: begin
        hs2_r   <= hs2_c;
        linkh_r <= fwd ? lk_eff : curr_r;
        prev2_r <= prev2_c;
        szp_r   <= (prev2_c == h_r) ? hs2_c : sz_clean;
      end
      CMD_F_M1: begin
        back_r <= (32'({prev2_r, 3'b000}) + 32'(szp_r)) == 32'({h_r, 3'b000});
        sum_r  <= szp_r + hs2_r;
      end
      CMD_RES: begin
        out_r.status          <= ctl.code;
        out_r.payload_address <= (ctl.code == ST_OK && act_r == ACT_ALLOC) ? pay_r : 16'd0;
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

// ===== src/fha_ctrl.sv =====
// Controller state machine: sequences list walks and updates, owns handshakes.
// Drives fha_datapath by command; depends on fha_pkg.
module fha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  fha_pkg::sts_t sts,
  output fha_pkg::ctl_t ctl
);
  import fha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_A_FIRST, S_A_WALK, S_A_SPLIT1, S_A_SPLIT2, S_A_TAKE,
    S_F_CHK, S_F_WALK, S_F_LAST, S_F_RD1, S_F_RD2, S_F_CALC, S_F_M1, S_F_M2,
    S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] code_r, code_nxt;
  logic       out_valid_r, out_valid_nxt;
  cmd_t       cmd;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = CMD_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.act == ACT_ALLOC) begin
          if (sts.refuse) begin
            code_nxt  = ST_REFUSED;
            state_nxt = S_DONE;
          end else if (sts.empty) begin
            code_nxt  = ST_NOFIT;
            state_nxt = S_DONE;
          end else begin
            cmd       = CMD_A_SEED;
            state_nxt = S_A_FIRST;
          end
        end else if (sts.bad) begin
          code_nxt  = ST_OK;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_F_RDH;
          state_nxt = S_F_CHK;
        end
      end
      S_A_FIRST: begin
        cmd       = CMD_A_FIRST;
        state_nxt = S_A_WALK;
      end
      S_A_WALK: begin
        cmd = CMD_A_STEP;
        if (sts.found) begin
          state_nxt = sts.split ? S_A_SPLIT1 : S_A_TAKE;
        end else if (sts.a_end) begin
          code_nxt  = ST_NOFIT;
          state_nxt = S_DONE;
        end
      end
      S_A_SPLIT1: begin
        cmd       = CMD_A_SPLIT1;
        state_nxt = S_A_SPLIT2;
      end
      S_A_SPLIT2, S_A_TAKE: begin
        cmd       = (state_r == S_A_TAKE) ? CMD_A_TAKE : CMD_A_SPLIT2;
        code_nxt  = ST_OK;
        state_nxt = S_DONE;
      end
      S_F_CHK: begin
        code_nxt = ST_OK;
        if (!sts.used) begin
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_F_CLR;
          state_nxt = sts.empty ? S_DONE : S_F_WALK;
        end
      end
      S_F_WALK: begin
        cmd = CMD_F_STEP;
        if (sts.f_brk) state_nxt = S_F_RD1;
        else if (sts.f_end) state_nxt = S_F_LAST;
      end
      S_F_LAST: begin
        cmd       = CMD_F_LAST;
        state_nxt = S_F_RD1;
      end
      S_F_RD1: begin
        cmd       = CMD_F_RD1;
        state_nxt = S_F_RD2;
      end
      S_F_RD2: begin
        cmd       = CMD_F_RD2;
        state_nxt = S_F_CALC;
      end
      S_F_CALC: begin
        cmd       = CMD_F_CALC;
        state_nxt = S_F_M1;
      end
      S_F_M1: begin
        cmd       = CMD_F_M1;
        state_nxt = S_F_M2;
      end
      S_F_M2: begin
        cmd       = CMD_F_M2;
        code_nxt  = ST_OK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd       = CMD_RES;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd == CMD_RES) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign ctl.cmd   = cmd;
  assign ctl.code  = code_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_RES |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while pending");

  a_load_disp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DISP)
    else $error("accepted request not dispatched");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && !out_ready |=> state_r == S_DONE)
    else $error("finished request left before result slot freed");

endmodule
